// ----- sv/pcs_pkg.sv -----
// Types, constants and codes shared by the contrast stretch block.
`timescale 1ns / 1ps

package pcs_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned INDEX_W    = 12;
  localparam int unsigned GREY_W     = 8;
  localparam int unsigned BOUND_W    = 17;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned PCT_W      = 14;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned PCT_SCALE   = 10000;
  localparam int unsigned GREY_MAX    = 255;
  localparam int unsigned GREY_STEPS  = 8;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GREY      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOAD_DONE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  localparam logic [MODE_W-1:0] MODE_FULL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIXED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PERCENT = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_MODE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_LEVEL    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_LEVEL   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_PERCENT  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_PERCENT = 3'd4;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic [INDEX_W-1:0]         index;
  } pcs_in_t;

  typedef struct packed {
    logic [GREY_W-1:0]   grey;
    logic [BOUND_W-1:0]  low_bound;
    logic [BOUND_W-1:0]  high_bound;
    logic [STATUS_W-1:0] status;
  } pcs_out_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
  } pcs_cfg_t;

  typedef struct packed {
    logic accept;
    logic load_bounds;
    logic clr_step;
    logic pix_rd_item;
    logic mul_norm;
    logic div_norm;
    logic hist_inc;
    logic walk_init;
    logic walk_rd;
    logic walk_acc;
    logic walk_lo_done;
    logic walk_hi_done;
    logic grey_prep;
    logic div_grey;
    logic resp;
  } pcs_cmd_t;

  typedef struct packed {
    logic kind;
    logic last;
    logic full;
    logic ready;
    logic index_bad;
    logic pct_mode;
    logic clr_last;
    logic pix_last;
    logic div_busy;
    logic walk_go;
    logic out_free;
  } pcs_sts_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_CLEAR,
    S_H_RD,
    S_H_MUL,
    S_H_DST,
    S_H_DWT,
    S_H_HRD,
    S_H_INC,
    S_W_INIT,
    S_W_CHK_LO,
    S_W_ACC_LO,
    S_W_CHK_HI,
    S_W_ACC_HI,
    S_R_RD,
    S_R_MUL,
    S_R_DST,
    S_R_DWT,
    S_G_PREP,
    S_G_DST,
    S_G_DWT,
    S_RESP
  } pcs_state_e;

endpackage

// ----- sv/pcs_chan_if.sv -----
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps

interface pcs_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/pcs_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pcs_div #(
  parameter int unsigned QW = 16,
  localparam int unsigned CW = $clog2(QW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [CW-1:0] steps_i,
  input  logic [31:0]   den_i,
  output logic          busy_o,
  output logic [QW-1:0] quot_o
);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   rem_q, den_q;
  logic [QW-1:0] low_q, quot_q;
  logic [32:0]   trial, diff;
  logic          ge;

  // rem_i must be below den_i, so the partial remainder stays in 32 bits
  assign trial = {rem_q, low_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      low_q  <= low_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[31:0] : trial[31:0];
      low_q  <= low_q << 1;
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ----- sv/pcs_datapath.sv -----
// Datapath: registers, pixel store, level histogram, divider and result register.
`timescale 1ns / 1ps

module pcs_datapath #(
  parameter int unsigned MAX_PIXELS = 4096,
  parameter int unsigned LEVELS     = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcs_pkg::pcs_in_t  in_data_i,
  input  logic              cfg_valid_i,
  input  pcs_pkg::pcs_cfg_t cfg_data_i,
  input  pcs_pkg::pcs_cmd_t cmd_i,
  output pcs_pkg::pcs_sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output pcs_pkg::pcs_out_t out_data_o
);

  localparam int unsigned SAW = $clog2(MAX_PIXELS);
  localparam int unsigned TW  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned LW  = $clog2(LEVELS);
  localparam int unsigned LVW = $clog2(LEVELS + 1);
  localparam int unsigned PW  = 32 + LVW;
  localparam int unsigned TGW = TW + pcs_pkg::PCT_W;
  localparam int unsigned BW  = pcs_pkg::BOUND_W;
  localparam int unsigned GNW = BW + pcs_pkg::GREY_STEPS;
  localparam int unsigned CW  = $clog2(LW + 1);
  localparam int unsigned GS  = pcs_pkg::GREY_STEPS;

  // configuration
  logic [pcs_pkg::MODE_W-1:0]  mode_q;
  logic [pcs_pkg::LEVEL_W-1:0] low_lvl_q, high_lvl_q;
  logic [pcs_pkg::PCT_W-1:0]   low_pct_q, high_pct_q;

  // image state
  logic [TW-1:0]     total_q;
  logic signed [31:0] min_q, max_q;
  logic              ready_q, full_q;
  logic [BW-1:0]     lower_q, upper_q;
  logic [LW-1:0]     cidx_q;
  logic [TW-1:0]     pidx_q;
  logic [LVW-1:0]    lvl_q;
  logic [TGW-1:0]    acc_q, tgt_q;
  logic              out_valid_q;

  // payload
  pcs_pkg::pcs_in_t  item_q;
  pcs_pkg::pcs_out_t out_q, resp_d;
  logic [31:0]       st_rd_q;
  logic [TW-1:0]     h_rd_q;
  logic [PW-1:0]     prod_q;
  logic              eq_q, flat_q;
  logic [GNW-1:0]    gnum_q;
  logic              gtop_q, gzero_q;

  logic [31:0] store_mem [MAX_PIXELS];
  logic [TW-1:0] hist_mem [LEVELS];

  logic [TW-1:0]  tot_eff;
  logic           full_now, load_now;
  logic [SAW-1:0] st_ra;
  logic signed [31:0] pix_s;
  logic [32:0]    d_full, span_full;
  logic [31:0]    d_val, span;
  logic [LW-1:0]  div_quot, n_val;
  logic           div_busy, div_start;
  logic [31:0]    div_rem, div_den;
  logic [LW-1:0]  div_low;
  logic [CW-1:0]  div_steps;
  logic [BW-1:0]  x_b, xc, dx, gspan;
  logic [GNW-1:0] gnum_d;
  logic [pcs_pkg::GREY_W-1:0] grey_val;
  logic           h_we;
  logic [LW-1:0]  h_wa, h_ra;
  logic [TW-1:0]  h_wd;
  logic           idx_bad;
  logic [pcs_pkg::STATUS_W-1:0] status_d;

  // a finished image starts over on the next load
  assign tot_eff  = ready_q ? '0 : total_q;
  assign full_now = tot_eff >= TW'(MAX_PIXELS);
  assign load_now = cmd_i.accept && (in_data_i.kind == pcs_pkg::KIND_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= pcs_pkg::MODE_FULL;
      low_lvl_q  <= '0;
      high_lvl_q <= '1;
      low_pct_q  <= '0;
      high_pct_q <= pcs_pkg::PCT_W'(pcs_pkg::PCT_SCALE);
    end else if (cfg_valid_i) begin
      unique case (cfg_data_i.addr)
        pcs_pkg::CFG_SCALE_MODE:   mode_q     <= cfg_data_i.wdata[pcs_pkg::MODE_W-1:0];
        pcs_pkg::CFG_LOW_LEVEL:    low_lvl_q  <= cfg_data_i.wdata;
        pcs_pkg::CFG_HIGH_LEVEL:   high_lvl_q <= cfg_data_i.wdata;
        pcs_pkg::CFG_LOW_PERCENT:  low_pct_q  <= cfg_data_i.wdata[pcs_pkg::PCT_W-1:0];
        pcs_pkg::CFG_HIGH_PERCENT: high_pct_q <= cfg_data_i.wdata[pcs_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      ready_q     <= 1'b0;
      full_q      <= 1'b0;
      lower_q     <= '0;
      upper_q     <= '0;
      cidx_q      <= '0;
      pidx_q      <= '0;
      lvl_q       <= '0;
      acc_q       <= '0;
      tgt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_now) begin
        full_q  <= full_now;
        ready_q <= 1'b0;
        cidx_q  <= '0;
        pidx_q  <= '0;
        if (!full_now) begin
          total_q <= tot_eff + TW'(1);
          if (tot_eff == '0 || in_data_i.sample < min_q) begin
            min_q <= in_data_i.sample;
          end
          if (tot_eff == '0 || in_data_i.sample > max_q) begin
            max_q <= in_data_i.sample;
          end
        end else begin
          total_q <= tot_eff;
        end
      end
      if (cmd_i.load_bounds) begin
        if (mode_q == pcs_pkg::MODE_FIXED) begin
          lower_q <= BW'(low_lvl_q);
          upper_q <= BW'(high_lvl_q);
        end else begin
          lower_q <= '0;
          upper_q <= BW'(LEVELS - 1);
        end
      end
      if (cmd_i.clr_step) begin
        cidx_q <= cidx_q + LW'(1);
      end
      if (cmd_i.hist_inc) begin
        pidx_q <= pidx_q + TW'(1);
      end
      if (cmd_i.walk_init) begin
        lvl_q <= '0;
        acc_q <= '0;
        tgt_q <= TGW'(low_pct_q) * TGW'(total_q);
      end
      if (cmd_i.walk_acc) begin
        acc_q <= acc_q + TGW'(h_rd_q) * TGW'(pcs_pkg::PCT_SCALE);
        lvl_q <= lvl_q + LVW'(1);
      end
      // high walk resumes where the low walk stopped
      if (cmd_i.walk_lo_done) begin
        lower_q <= BW'(lvl_q);
        tgt_q   <= TGW'(high_pct_q) * TGW'(total_q);
      end
      if (cmd_i.walk_hi_done) begin
        upper_q <= BW'(lvl_q);
      end
      if (cmd_i.resp) begin
        out_valid_q <= 1'b1;
        if (item_q.kind == pcs_pkg::KIND_LOAD && item_q.last) begin
          ready_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pixel store
  assign st_ra = cmd_i.pix_rd_item ? SAW'(item_q.index) : pidx_q[SAW-1:0];

  always_ff @(posedge clk_i) begin
    if (load_now && !full_now) begin
      store_mem[tot_eff[SAW-1:0]] <= in_data_i.sample;
    end
    st_rd_q <= store_mem[st_ra];
  end

  // level histogram
  assign h_we = cmd_i.clr_step || cmd_i.hist_inc;
  assign h_wa = cmd_i.clr_step ? cidx_q : n_val;
  assign h_wd = cmd_i.clr_step ? '0 : h_rd_q + TW'(1);
  assign h_ra = cmd_i.walk_rd ? lvl_q[LW-1:0] : n_val;

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hist_mem[h_wa] <= h_wd;
    end
    h_rd_q <= hist_mem[h_ra];
  end

  // normalization: n = d*LEVELS/span, LEVELS-1 when d equals span, 0 for a flat image
  assign pix_s     = st_rd_q;
  assign d_full    = {pix_s[31], pix_s} - {min_q[31], min_q};
  assign span_full = {max_q[31], max_q} - {min_q[31], min_q};
  assign d_val     = (pix_s > min_q) ? d_full[31:0] : '0;
  assign span      = span_full[31:0];
  assign n_val     = flat_q ? '0 : (eq_q ? LW'(LEVELS - 1) : div_quot);

  // grey: (clamp(n)-lo)*255/(hi-lo)
  assign x_b    = BW'(n_val);
  assign xc     = (x_b < lower_q) ? lower_q : ((x_b > upper_q) ? upper_q : x_b);
  assign dx     = xc - lower_q;
  assign gnum_d = (GNW'(dx) << GS) - GNW'(dx);
  assign gspan  = upper_q - lower_q;
  assign grey_val = gzero_q ? '0 :
                    (gtop_q ? pcs_pkg::GREY_W'(pcs_pkg::GREY_MAX) : div_quot[pcs_pkg::GREY_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.mul_norm) begin
      prod_q <= PW'(d_val) * PW'(LEVELS);
      eq_q   <= d_val == span;
      flat_q <= !(max_q > min_q);
    end
    if (cmd_i.grey_prep) begin
      gnum_q  <= gnum_d;
      gtop_q  <= xc == upper_q;
      gzero_q <= !(upper_q > lower_q);
    end
    if (cmd_i.resp) begin
      out_q <= resp_d;
    end
  end

  assign div_start = cmd_i.div_norm || cmd_i.div_grey;
  assign div_rem   = cmd_i.div_grey ? 32'(gnum_q[GNW-1:GS]) : prod_q[LW+31:LW];
  assign div_low   = cmd_i.div_grey ? (LW'(gnum_q[GS-1:0]) << (LW - GS)) : prod_q[LW-1:0];
  assign div_den   = cmd_i.div_grey ? 32'(gspan) : span;
  assign div_steps = cmd_i.div_grey ? CW'(GS) : CW'(LW);

  pcs_div #(.QW(LW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .low_i   (div_low),
    .steps_i (div_steps),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // result beat
  assign idx_bad = 32'(item_q.index) >= 32'(total_q);

  always_comb begin
    if (item_q.kind == pcs_pkg::KIND_LOAD) begin
      status_d = full_q ? pcs_pkg::ST_FULL : pcs_pkg::ST_LOAD_DONE;
    end else if (!ready_q) begin
      status_d = pcs_pkg::ST_NOT_READY;
    end else if (idx_bad) begin
      status_d = pcs_pkg::ST_BAD_INDEX;
    end else begin
      status_d = pcs_pkg::ST_GREY;
    end
    resp_d.grey       = (status_d == pcs_pkg::ST_GREY) ? grey_val : '0;
    resp_d.low_bound  = lower_q;
    resp_d.high_bound = upper_q;
    resp_d.status     = status_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.kind      = item_q.kind;
  assign sts_o.last      = item_q.last;
  assign sts_o.full      = full_q;
  assign sts_o.ready     = ready_q;
  assign sts_o.index_bad = idx_bad;
  assign sts_o.pct_mode  = mode_q == pcs_pkg::MODE_PERCENT;
  assign sts_o.clr_last  = cidx_q == LW'(LEVELS - 1);
  assign sts_o.pix_last  = (pidx_q + TW'(1)) == total_q;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.walk_go   = (lvl_q < LVW'(LEVELS)) && (acc_q < tgt_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resp |-> (!out_valid_q || out_ready_i))
    else $error("result beat overwritten");

  a_ready_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (total_q != '0))
    else $error("image ready with no pixels");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_norm || cmd_i.div_grey) |-> !div_busy)
    else $error("divider restarted while busy");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != $past(total_q)) |-> ((total_q == $past(total_q) + TW'(1)) ||
                                     (total_q == TW'(1))))
    else $error("pixel count jumped");
`endif

endmodule

// ----- sv/pcs_ctrl.sv -----
// Controller state machine sequencing the datapath.
`timescale 1ns / 1ps

module pcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pcs_pkg::pcs_sts_t sts_i,
  output pcs_pkg::pcs_cmd_t cmd_o
);

  pcs_pkg::pcs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pcs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = pcs_pkg::S_DISPATCH;
        end
      end
      pcs_pkg::S_DISPATCH: begin
        if (sts_i.kind == pcs_pkg::KIND_LOAD) begin
          if (sts_i.last) begin
            if (sts_i.pct_mode) begin
              state_d = pcs_pkg::S_CLEAR;
            end else begin
              cmd_o.load_bounds = 1'b1;
              state_d           = pcs_pkg::S_RESP;
            end
          end else begin
            state_d = sts_i.full ? pcs_pkg::S_RESP : pcs_pkg::S_IDLE;
          end
        end else if (!sts_i.ready || sts_i.index_bad) begin
          state_d = pcs_pkg::S_RESP;
        end else begin
          state_d = pcs_pkg::S_R_RD;
        end
      end
      pcs_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = pcs_pkg::S_H_RD;
        end
      end
      pcs_pkg::S_H_RD:  state_d = pcs_pkg::S_H_MUL;
      pcs_pkg::S_H_MUL: begin
        cmd_o.mul_norm = 1'b1;
        state_d        = pcs_pkg::S_H_DST;
      end
      pcs_pkg::S_H_DST: begin
        cmd_o.div_norm = 1'b1;
        state_d        = pcs_pkg::S_H_DWT;
      end
      pcs_pkg::S_H_DWT: begin
        if (!sts_i.div_busy) begin
          state_d = pcs_pkg::S_H_HRD;
        end
      end
      pcs_pkg::S_H_HRD: state_d = pcs_pkg::S_H_INC;
      pcs_pkg::S_H_INC: begin
        cmd_o.hist_inc = 1'b1;
        state_d        = sts_i.pix_last ? pcs_pkg::S_W_INIT : pcs_pkg::S_H_RD;
      end
      pcs_pkg::S_W_INIT: begin
        cmd_o.walk_init = 1'b1;
        state_d         = pcs_pkg::S_W_CHK_LO;
      end
      pcs_pkg::S_W_CHK_LO: begin
        if (sts_i.walk_go) begin
          cmd_o.walk_rd = 1'b1;
          state_d       = pcs_pkg::S_W_ACC_LO;
        end else begin
          cmd_o.walk_lo_done = 1'b1;
          state_d            = pcs_pkg::S_W_CHK_HI;
        end
      end
      pcs_pkg::S_W_ACC_LO: begin
        cmd_o.walk_acc = 1'b1;
        state_d        = pcs_pkg::S_W_CHK_LO;
      end
      pcs_pkg::S_W_CHK_HI: begin
        if (sts_i.walk_go) begin
          cmd_o.walk_rd = 1'b1;
          state_d       = pcs_pkg::S_W_ACC_HI;
        end else begin
          cmd_o.walk_hi_done = 1'b1;
          state_d            = pcs_pkg::S_RESP;
        end
      end
      pcs_pkg::S_W_ACC_HI: begin
        cmd_o.walk_acc = 1'b1;
        state_d        = pcs_pkg::S_W_CHK_HI;
      end
      pcs_pkg::S_R_RD: begin
        cmd_o.pix_rd_item = 1'b1;
        state_d           = pcs_pkg::S_R_MUL;
      end
      pcs_pkg::S_R_MUL: begin
        cmd_o.mul_norm = 1'b1;
        state_d        = pcs_pkg::S_R_DST;
      end
      pcs_pkg::S_R_DST: begin
        cmd_o.div_norm = 1'b1;
        state_d        = pcs_pkg::S_R_DWT;
      end
      pcs_pkg::S_R_DWT: begin
        if (!sts_i.div_busy) begin
          state_d = pcs_pkg::S_G_PREP;
        end
      end
      pcs_pkg::S_G_PREP: begin
        cmd_o.grey_prep = 1'b1;
        state_d         = pcs_pkg::S_G_DST;
      end
      pcs_pkg::S_G_DST: begin
        cmd_o.div_grey = 1'b1;
        state_d        = pcs_pkg::S_G_DWT;
      end
      pcs_pkg::S_G_DWT: begin
        if (!sts_i.div_busy) begin
          state_d = pcs_pkg::S_RESP;
        end
      end
      pcs_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp = 1'b1;
          state_d    = pcs_pkg::S_IDLE;
        end
      end
      default: state_d = pcs_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- sv/percentile_contrast_stretch_core.sv -----
// Load: a last load adds the bounds pass before its result beat.
// Percentile pass: clear every level, then per stored pixel read, scale, divide
// and count its level, then walk the levels. Other modes load the bounds directly.
// Read: two passes through the shared bit-serial divider, normalization then grey.
// One item in flight; the result register lets the next item enter while a beat waits.
// Reset is asynchronous active low; store and histogram contents are not reset.
`timescale 1ns / 1ps

module percentile_contrast_stretch_core #(
  parameter int unsigned MAX_PIXELS = 4096,
  parameter int unsigned LEVELS     = 65536
) (
  input logic           clk_i,
  input logic           rst_ni,
  pcs_chan_if.sink      in_i,
  pcs_chan_if.source    out_o,
  pcs_chan_if.sink      cfg_i
);

  pcs_pkg::pcs_cmd_t cmd;
  pcs_pkg::pcs_sts_t sts;

  assign cfg_i.ready = 1'b1;

  pcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcs_datapath #(
    .MAX_PIXELS (MAX_PIXELS),
    .LEVELS     (LEVELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

endmodule
